[src/tqv_pkg.sv]
// Shared constants and types of the trellis quantizer Viterbi search.
// Used by tqv_dist and by the top level trellis_quantizer_viterbi.
package tqv_pkg;

  localparam int COMP_W   = 16;   // one Q3.12 vector component
  localparam int SQ_W     = 32;   // square of one component difference
  localparam int DIST_W   = 34;   // sum of up to four squares
  localparam int WEIGHT_W = 16;   // Q8.8 step weight
  localparam int PROD_W   = 50;   // weighted distance
  localparam int COST_W   = 56;   // path cost, all ones is infinity

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // Input word actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // Register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOUR_COMP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OV_ENABLE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OV_COLUMN  = 2'd3;

  typedef struct packed {
    logic valid;
    logic four;
  } dist_req_t;

endpackage

[src/tqv_dist.sv]
// Weighted squared distance unit: three stage pipeline (squares, sum, weight).
// Depends on tqv_pkg for field widths and the request struct.
module tqv_dist (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  tqv_pkg::dist_req_t                     req_i,
  input  logic [4*tqv_pkg::COMP_W-1:0]           target_i,
  input  logic [4*tqv_pkg::COMP_W-1:0]           code_i,
  input  logic [tqv_pkg::WEIGHT_W-1:0]           weight_i,
  output logic                                   valid_o,
  output logic [tqv_pkg::PROD_W-1:0]             prod_o
);

  logic signed [tqv_pkg::COMP_W:0]     diff [4];
  logic signed [2*tqv_pkg::COMP_W+1:0] sqs  [4];
  logic [tqv_pkg::SQ_W-1:0]            sq_d [4];
  logic [tqv_pkg::SQ_W-1:0]            sq_q [4];
  logic [tqv_pkg::DIST_W-1:0]          sum_d, sum_q;
  logic [tqv_pkg::PROD_W-1:0]          prod_d, prod_q;
  logic                                v1_q, v2_q, v3_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      diff[k] = $signed({target_i[16*k+15], target_i[16*k +: 16]})
              - $signed({code_i[16*k+15], code_i[16*k +: 16]});
      sqs[k]  = diff[k] * diff[k];
      // drop the upper lanes for two component vectors
      sq_d[k] = (k < 2 || req_i.four) ? sqs[k][tqv_pkg::SQ_W-1:0] : '0;
    end
  end

  assign sum_d = tqv_pkg::DIST_W'(sq_q[0]) + tqv_pkg::DIST_W'(sq_q[1])
               + tqv_pkg::DIST_W'(sq_q[2]) + tqv_pkg::DIST_W'(sq_q[3]);
  assign prod_d = sum_q * weight_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      sq_q <= sq_d;
    end
    if (v1_q) begin
      sum_q <= sum_d;
    end
    if (v2_q) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = v3_q;
  assign prod_o  = prod_q;

endmodule

[src/trellis_quantizer_viterbi.sv]
// Top level of the bit-shift trellis quantizer Viterbi search.
// Depends on tqv_pkg and tqv_dist; holds the codebook, cost and backpointer memories.
//
// Load the codebook with action 0 words, then send the target steps of one sequence
// with action 1, marking the final one with last_step. A step scores all 2^STATE_BITS
// states through the single distance unit, one state per cycle, then copies the new
// column costs over the old ones. A load does not stall the input.
// After the last step the end column search tries each candidate column in turn,
// then the traceback emits one result word per backpointer memory read, from the
// last step down to step zero. Input is stalled until the word in hand is finished;
// a waiting result does not hold up the next input.
module trellis_quantizer_viterbi #(
  parameter int STATE_BITS = 8,
  parameter int MAX_STEPS  = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tqv_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tqv_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [7:0]                        entry_index_i,
  input  logic signed [15:0]                comp_zero_i,
  input  logic signed [15:0]                comp_one_i,
  input  logic signed [15:0]                comp_two_i,
  input  logic signed [15:0]                comp_three_i,
  input  logic [15:0]                       step_weight_i,
  input  logic                              last_step_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [5:0]                        step_index_o,
  output logic [7:0]                        chosen_state_o,
  output logic [55:0]                       total_error_o,
  output logic                              last_out_o
);

  localparam int SB  = STATE_BITS;
  localparam int NST = 1 << SB;
  localparam int SUF = 1 << (SB - 1);
  localparam int XW  = SB - 1;
  localparam int STW = $clog2(MAX_STEPS);
  localparam int SCW = $clog2(MAX_STEPS + 1);
  localparam int SHW = $clog2(SB + 1);
  localparam int BPA = STW + XW;
  localparam int BPD = MAX_STEPS * SUF;
  localparam int CW  = tqv_pkg::COST_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCORE = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_COPY  = 3'd3;
  localparam logic [2:0] ST_FSET  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;
  localparam logic [2:0] ST_TBW   = 3'd7;

  typedef struct packed {
    logic          valid;
    logic          first;
    logic          last;
    logic          kill;
    logic [SB-1:0] h;
    logic [XW-1:0] x;
  } tag_t;

  // configuration
  logic [3:0] shift_bits_q;
  logic       four_comp_q, ov_en_q;
  logic [7:0] ov_col_q;

  // control
  logic [2:0]     state_q;
  logic [SCW-1:0] step_cnt_q, n_q;
  logic           last_q;
  logic [SB-1:0]  h_q;
  logic [XW-1:0]  x_q;
  tag_t           tag_q [1:5];
  tag_t           tag0;
  logic           cp_run_q, cp_v_q;
  logic [XW-1:0]  cx_q, cp_a_q;
  logic [SB-1:0]  fx_q, fend_q;
  logic           fin_v_q;
  logic [XW-1:0]  fin_x_q;
  logic [STW-1:0] k_q;
  logic [XW-1:0]  col_q;
  logic           out_valid_q;

  // payload
  logic [4*tqv_pkg::COMP_W-1:0] target_q;
  logic [15:0]                  weight_q;
  logic [CW-1:0]                cold2_q, cold3_q, cold4_q, val_q;
  logic [CW-1:0]                bv_q, best_q;
  logic [SB-1:0]                bh_q, es_q, s_q;
  logic [5:0]                   step_index_q;
  logic [7:0]                   chosen_state_q;
  logic [CW-1:0]                total_error_q;
  logic                         last_out_q;

  // memories
  logic [63:0]   cb_mem       [NST];
  logic [CW-1:0] cost_old_mem [SUF];
  logic [CW-1:0] cost_new_mem [SUF];
  logic [SB-1:0] bp_mem       [BPD];
  logic [63:0]   cb_rd_q;
  logic [CW-1:0] cold_rd_q, cnew_rd_q;
  logic [SB-1:0] bp_rd_q;

  logic [SHW-1:0] sh, rsh;
  logic [SB-1:0]  pc_m1, sc_full, issue_state, pred_full, cand, tb_state;
  logic [XW-1:0]  sc_m1, pred, emit_col;
  logic           ov_valid, kill, in_acc, cb_we, st0;
  logic [XW-1:0]  cold_raddr;
  logic [BPA-1:0] bp_raddr;
  logic [CW:0]    sat_sum;
  logic [CW-1:0]  val_d, cur_bv, nbv;
  logic [SB-1:0]  cur_bh, nbh;
  logic           out_load, slot_free, fin_issue, fin_take;
  logic           dist_v;
  logic [tqv_pkg::PROD_W-1:0] dist_prod;
  tqv_pkg::dist_req_t dist_req;

  // effective shift, clamped to 1..STATE_BITS
  always_comb begin
    if (shift_bits_q == 4'd0) begin
      sh = SHW'(1);
    end else if (int'(shift_bits_q) > SB) begin
      sh = SHW'(SB);
    end else begin
      sh = SHW'(shift_bits_q);
    end
  end

  assign rsh      = SHW'(SB) - sh;
  assign pc_m1    = ~({SB{1'b1}} << sh);
  assign sc_m1    = ~({XW{1'b1}} << rsh);
  assign sc_full  = SB'(1) << rsh;
  assign ov_valid = int'(ov_col_q) < int'(sc_full);
  assign st0      = (step_cnt_q == '0);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cb_we      = in_acc && (action_i == tqv_pkg::ACT_LOAD) && (int'(entry_index_i) < NST);

  // issue stage: state = prefix * columns + column
  assign issue_state = (h_q << rsh) | SB'(x_q);
  assign pred_full   = issue_state >> sh;
  assign pred        = pred_full[XW-1:0];
  assign kill        = st0 && ov_en_q && (!ov_valid || int'(pred) != int'(ov_col_q));

  always_comb begin
    tag0       = '0;
    tag0.valid = (state_q == ST_SCORE);
    tag0.first = (h_q == '0);
    tag0.last  = (h_q == pc_m1);
    tag0.kill  = kill;
    tag0.h     = h_q;
    tag0.x     = x_q;
  end

  assign cold_raddr = (state_q == ST_FIN) ? fx_q[XW-1:0] : pred;
  assign emit_col   = XW'(s_q >> sh);
  assign bp_raddr   = (state_q == ST_FIN) ? {STW'(n_q - SCW'(1)), fx_q[XW-1:0]}
                                          : {STW'(k_q - STW'(1)), emit_col};

  assign dist_req.valid = tag_q[1].valid;
  assign dist_req.four  = four_comp_q;

  tqv_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (dist_req),
    .target_i (target_q),
    .code_i   (cb_rd_q),
    .weight_i (weight_q),
    .valid_o  (dist_v),
    .prod_o   (dist_prod)
  );

  // add predecessor cost, saturating; step zero adds none
  assign sat_sum = (CW+1)'(dist_prod) + {1'b0, cold4_q};
  always_comb begin
    if (tag_q[4].kill) begin
      val_d = tqv_pkg::COST_MAX;
    end else if (st0) begin
      val_d = CW'(dist_prod);
    end else if (sat_sum[CW]) begin
      val_d = tqv_pkg::COST_MAX;
    end else begin
      val_d = sat_sum[CW-1:0];
    end
  end

  // running minimum over the prefixes of a column; lowest prefix wins ties
  assign cur_bv = tag_q[5].first ? tqv_pkg::COST_MAX : bv_q;
  assign cur_bh = tag_q[5].first ? '0 : bh_q;
  assign nbv    = (val_q < cur_bv) ? val_q : cur_bv;
  assign nbh    = (val_q < cur_bv) ? tag_q[5].h : cur_bh;

  // end column search and traceback
  assign fin_issue = (state_q == ST_FIN) && (fx_q < fend_q);
  assign cand      = (bp_rd_q << rsh) | SB'(fin_x_q);
  assign fin_take  = (cold_rd_q < best_q) || (cold_rd_q == best_q && cand < es_q);
  assign tb_state  = (bp_rd_q << rsh) | SB'(col_q);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign out_load  = (state_q == ST_EMIT) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_bits_q <= 4'd1;
      four_comp_q  <= 1'b1;
      ov_en_q      <= 1'b0;
      ov_col_q     <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tqv_pkg::REG_SHIFT_BITS: shift_bits_q <= cfg_data_i[3:0];
        tqv_pkg::REG_FOUR_COMP:  four_comp_q  <= cfg_data_i[0];
        tqv_pkg::REG_OV_ENABLE:  ov_en_q      <= cfg_data_i[0];
        tqv_pkg::REG_OV_COLUMN:  ov_col_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_cnt_q  <= '0;
      n_q         <= '0;
      last_q      <= 1'b0;
      h_q         <= '0;
      x_q         <= '0;
      for (int i = 1; i <= 5; i++) begin
        tag_q[i] <= '0;
      end
      cp_run_q    <= 1'b0;
      cp_v_q      <= 1'b0;
      cx_q        <= '0;
      cp_a_q      <= '0;
      fx_q        <= '0;
      fend_q      <= '0;
      fin_v_q     <= 1'b0;
      fin_x_q     <= '0;
      k_q         <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tag_q[1] <= tag0;
      for (int i = 2; i <= 5; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
      out_valid_q <= out_load || (out_valid_q && out_stall_i);

      case (state_q)
        ST_IDLE: begin
          if (in_acc && action_i == tqv_pkg::ACT_STEP) begin
            last_q <= last_step_i;
            h_q    <= '0;
            x_q    <= '0;
            if (int'(step_cnt_q) < MAX_STEPS) begin
              state_q <= ST_SCORE;
            end else if (last_step_i) begin
              state_q <= ST_FSET;
            end
          end
        end
        ST_SCORE: begin
          if (h_q == pc_m1) begin
            h_q <= '0;
            if (x_q == sc_m1) begin
              state_q <= ST_DRAIN;
            end else begin
              x_q <= x_q + XW'(1);
            end
          end else begin
            h_q <= h_q + SB'(1);
          end
        end
        ST_DRAIN: begin
          if (!tag_q[1].valid && !tag_q[2].valid && !tag_q[3].valid &&
              !tag_q[4].valid && !tag_q[5].valid) begin
            state_q  <= ST_COPY;
            cp_run_q <= 1'b1;
            cx_q     <= '0;
          end
        end
        ST_COPY: begin
          cp_v_q <= cp_run_q;
          cp_a_q <= cx_q;
          if (cp_run_q) begin
            if (cx_q == sc_m1) begin
              cp_run_q <= 1'b0;
            end else begin
              cx_q <= cx_q + XW'(1);
            end
          end else if (!cp_v_q) begin
            step_cnt_q <= step_cnt_q + SCW'(1);
            state_q    <= last_q ? ST_FSET : ST_IDLE;
          end
        end
        ST_FSET: begin
          n_q        <= step_cnt_q;
          step_cnt_q <= '0;
          if (ov_en_q && step_cnt_q > SCW'(1)) begin
            fx_q   <= ov_valid ? SB'(ov_col_q) : '0;
            fend_q <= ov_valid ? SB'(ov_col_q) + SB'(1) : '0;
          end else begin
            fx_q   <= '0;
            fend_q <= sc_full;
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          fin_v_q <= fin_issue;
          fin_x_q <= fx_q[XW-1:0];
          if (fin_issue) begin
            fx_q <= fx_q + SB'(1);
          end else if (!fin_v_q) begin
            k_q     <= STW'(n_q - SCW'(1));
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            col_q   <= emit_col;
            state_q <= (k_q == '0) ? ST_IDLE : ST_TBW;
          end
        end
        ST_TBW: begin
          k_q     <= k_q - STW'(1);
          state_q <= ST_EMIT;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      target_q <= {comp_three_i, comp_two_i, comp_one_i, comp_zero_i};
      weight_q <= step_weight_i;
    end
    cold2_q <= cold_rd_q;
    cold3_q <= cold2_q;
    cold4_q <= cold3_q;
    val_q   <= val_d;
    if (tag_q[5].valid) begin
      bv_q <= nbv;
      bh_q <= nbh;
    end
    if (state_q == ST_FSET) begin
      best_q <= tqv_pkg::COST_MAX;
      es_q   <= '0;
    end else if (state_q == ST_FIN && fin_v_q && fin_take) begin
      best_q <= cold_rd_q;
      es_q   <= cand;
    end
    if (state_q == ST_FIN && !fin_issue && !fin_v_q) begin
      s_q <= es_q;
    end else if (state_q == ST_TBW) begin
      s_q <= tb_state;
    end
    if (out_load) begin
      step_index_q   <= 6'(k_q);
      chosen_state_q <= 8'(s_q);
      total_error_q  <= best_q;
      last_out_q     <= (k_q == '0);
    end
  end

  // memories, registered read
  always_ff @(posedge clk_i) begin
    if (cb_we) begin
      cb_mem[SB'(entry_index_i)] <= {comp_three_i, comp_two_i, comp_one_i, comp_zero_i};
    end
    cb_rd_q <= cb_mem[issue_state];
  end

  always_ff @(posedge clk_i) begin
    if (cp_v_q) begin
      cost_old_mem[cp_a_q] <= cnew_rd_q;
    end
    cold_rd_q <= cost_old_mem[cold_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tag_q[5].valid && tag_q[5].last) begin
      cost_new_mem[tag_q[5].x] <= nbv;
    end
    cnew_rd_q <= cost_new_mem[cx_q];
  end

  always_ff @(posedge clk_i) begin
    if (tag_q[5].valid && tag_q[5].last) begin
      bp_mem[{step_cnt_q[STW-1:0], tag_q[5].x}] <= nbh;
    end
    bp_rd_q <= bp_mem[bp_raddr];
  end

  assign out_valid_o    = out_valid_q;
  assign step_index_o   = step_index_q;
  assign chosen_state_o = chosen_state_q;
  assign total_error_o  = total_error_q;
  assign last_out_o     = last_out_q;

`ifndef SYNTHESIS
  a_dist_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_v == tag_q[4].valid)
    else $error("distance result out of step with its tag");

  a_min_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_q[5].valid |-> (state_q == ST_SCORE || state_q == ST_DRAIN))
    else $error("column minimum updated outside a step");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!tag_q[1].valid && !tag_q[5].valid && !cp_v_q && !fin_v_q))
    else $error("work in flight while taking input");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(step_cnt_q) <= MAX_STEPS)
    else $error("step counter past its limit");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && k_q == '0) |=> (state_q == ST_IDLE && last_out_q))
    else $error("final word did not end the run");
`endif

endmodule
